>>> rtl/etd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etd_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TIME_BIT    = 0;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int ID_W    = 8;
    localparam int MASK_W  = 8;
    localparam int TICK_W  = 32;
    localparam int TAG_W   = 8;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int THR_W   = 31;

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1000);
    localparam logic [MASK_W-1:0] TIME_MASK = MASK_W'(1) << TIME_BIT;
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SCAN   = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd4;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        EM_NONE,
        EM_FAIL,
        EM_SLOT,
        EM_PEND,
        EM_PEND_LAST
    } emit_t;

    typedef struct packed {
        act_t                action;
        logic [ID_W-1:0]     task_id;
        logic [MASK_W-1:0]   trigger_mask;
        logic                use_delay;
        logic [TICK_W-1:0]   delay_ticks;
        logic [TAG_W-1:0]    handler_tag;
        logic [TICK_W-1:0]   now_ticks;
        logic [MASK_W-1:0]   event_mask;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]   matched_id;
        logic [TAG_W-1:0]  matched_handler;
        logic              last_result;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  step;
        logic  wr;
        logic  pend_load;
        emit_t emit;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        act_t action;
        logic bad_id;
        logic hit;
        logic last_slot;
        logic pend_valid;
        logic out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

>>> rtl/etd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface etd_req_if;
    import etd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [ID_W-1:0]     task_id;
    logic [MASK_W-1:0]   trigger_mask;
    logic                use_delay;
    logic [TICK_W-1:0]   delay_ticks;
    logic [TAG_W-1:0]    handler_tag;
    logic [TICK_W-1:0]   now_ticks;
    logic [MASK_W-1:0]   event_mask;

    modport source (
        output valid, action, task_id, trigger_mask, use_delay, delay_ticks,
               handler_tag, now_ticks, event_mask,
        input  ready
    );

    modport sink (
        input  valid, action, task_id, trigger_mask, use_delay, delay_ticks,
               handler_tag, now_ticks, event_mask,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/etd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface etd_rsp_if;
    import etd_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   matched_id;
    logic [TAG_W-1:0]  matched_handler;
    logic              last_result;

    modport source (
        output valid, status, slot_index, matched_id, matched_handler, last_result,
        input  ready
    );

    modport sink (
        input  valid, status, slot_index, matched_id, matched_handler, last_result,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/event_timed_task_dispatch_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Task dispatch table with 16 slots (id, event mask, due time, handler tag).
// A request word on req is an add, a remove or a scan; answer words leave on
// rsp, each with last_result set on the final word of its request. An add
// takes the lowest free slot, a remove clears the lowest live slot with that
// id, and a scan returns every live slot whose mask meets event_mask, with a
// timed slot (time bit set) firing only while now_ticks - due lies in
// [0, late_threshold). Id 0 on add or remove answers bad id; action 3 is
// dropped with no answer. The table is walked one slot per cycle by a single
// compare unit while rsp does not hold it back. After the accept, an add or
// remove stops at its slot (a bad id at once), and a scan always visits
// all 16 slots and then emits its final word from a finish state. Stalls on
// rsp also hold the block: an add or remove waits for the output, a scan
// holds its walk while a match waits behind an untaken word. One word sits in
// the output register, so a new request is accepted while the final answer
// of the previous one is still waiting. Write late_threshold through
// cfg_we/cfg_wdata only while no request is in progress; it resets to 1000.
// Reset frees all slots at once; there is no clearing pass.

module event_timed_task_dispatch_table_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    etd_req_if.sink                        req,
    etd_rsp_if.source                      rsp,
    input  wire logic                      cfg_we,
    input  wire logic [etd_pkg::THR_W-1:0] cfg_wdata
);
    import etd_pkg::*;

    req_t      req_data;
    rsp_t      rsp_data;
    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_st;

    // Pack the request word for the datapath
    assign req_data.action       = act_t'(req.action);
    assign req_data.task_id      = req.task_id;
    assign req_data.trigger_mask = req.trigger_mask;
    assign req_data.use_delay    = req.use_delay;
    assign req_data.delay_ticks  = req.delay_ticks;
    assign req_data.handler_tag  = req.handler_tag;
    assign req_data.now_ticks    = req.now_ticks;
    assign req_data.event_mask   = req.event_mask;

    // Sequencer: accept, walk the slots, emit answers
    etd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (ctl_st),
        .cmd       (ctl_cmd)
    );

    // Slot table, compare unit, pending match and output register
    etd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctl_cmd),
        .st        (ctl_st),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    // Unpack the answer word
    assign rsp.status          = rsp_data.status;
    assign rsp.slot_index      = rsp_data.slot_index;
    assign rsp.matched_id      = rsp_data.matched_id;
    assign rsp.matched_handler = rsp_data.matched_handler;
    assign rsp.last_result     = rsp_data.last_result;

`ifndef SYNTHESIS
    // A failure answer always closes its request
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> rsp.last_result)
        else $error("failure word without last_result");

    // A failure answer carries no slot, id or tag
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |->
            (rsp.slot_index == '0) && (rsp.matched_id == '0)
            && (rsp.matched_handler == '0))
        else $error("failure word with nonzero payload");

    // An accepted request keeps the block busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while previous one still walking");

    // A held scan match never outlives its request
    a_pend_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_st.pend_valid |-> !req.ready)
        else $error("pending match left over while idle");
`endif

endmodule

`default_nettype wire

>>> rtl/etd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module etd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire etd_pkg::ctl_stat_t st,
    output etd_pkg::ctl_cmd_t       cmd
);
    import etd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.wr        = 1'b0;
        cmd.pend_load = 1'b0;
        cmd.emit      = EM_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (st.action == ACT_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (st.action != ACT_SCAN)
                begin
                    if (st.bad_id || st.hit || st.last_slot)
                    begin
                        // finish here once the output register can take the word
                        if (st.out_free)
                        begin
                            if (!st.bad_id && st.hit)
                            begin
                                cmd.wr   = 1'b1;
                                cmd.emit = EM_SLOT;
                            end
                            else
                            begin
                                cmd.emit = EM_FAIL;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
                else if (!(st.hit && st.pend_valid && !st.out_free))
                begin
                    // push the older match out, hold the new one back
                    if (st.hit)
                    begin
                        cmd.pend_load = 1'b1;
                        if (st.pend_valid)
                        begin
                            cmd.emit = EM_PEND;
                        end
                    end
                    if (st.last_slot)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = st.pend_valid ? EM_PEND_LAST : EM_FAIL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/etd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module etd_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire etd_pkg::req_t             req_data,
    input  wire logic                      cfg_we,
    input  wire logic [etd_pkg::THR_W-1:0] cfg_wdata,
    input  wire etd_pkg::ctl_cmd_t         cmd,
    output etd_pkg::ctl_stat_t             st,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output etd_pkg::rsp_t                  rsp_data
);
    import etd_pkg::*;

    // Slot table: id and mask clear at reset, due time and tag only on add
    logic [ID_W-1:0]   ident_reg   [TABLE_DEPTH];
    logic [MASK_W-1:0] events_reg  [TABLE_DEPTH];
    logic [TICK_W-1:0] due_reg     [TABLE_DEPTH];
    logic [TAG_W-1:0]  handler_reg [TABLE_DEPTH];

    logic [THR_W-1:0]  thr_reg;
    req_t              cmd_reg;
    logic [TICK_W-1:0] cmd_due_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              pend_valid_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic [TAG_W-1:0]  pend_tag_reg;

    logic              out_valid_reg;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic [ID_W-1:0]   cur_ident;
    logic [MASK_W-1:0] cur_events;
    logic [TICK_W-1:0] cur_due;
    logic [TICK_W-1:0] age;
    logic              timely;
    logic              add_hit;
    logic              rem_hit;
    logic              scan_hit;
    logic [MASK_W-1:0] add_events;
    logic [STAT_W-1:0] fail_code;

    assign cur_ident  = ident_reg[idx_reg];
    assign cur_events = events_reg[idx_reg];
    assign cur_due    = due_reg[idx_reg];

    assign age      = cmd_reg.now_ticks - cur_due;
    assign timely   = !age[TICK_W-1] && (age[THR_W-1:0] < thr_reg);
    assign add_hit  = (cur_ident == '0);
    assign rem_hit  = (cur_events != '0) && (cur_ident == cmd_reg.task_id);
    assign scan_hit = ((cur_events & cmd_reg.event_mask) != '0)
                      && (!cur_events[TIME_BIT] || timely);

    assign add_events = cmd_reg.use_delay ? (cmd_reg.trigger_mask | TIME_MASK)
                                          : cmd_reg.trigger_mask;

    always_comb
    begin
        case (cmd_reg.action)
            ACT_ADD:    st.hit = add_hit;
            ACT_REMOVE: st.hit = rem_hit;
            ACT_SCAN:   st.hit = scan_hit;
            default:    st.hit = 1'b0;
        endcase
    end

    assign st.action     = cmd_reg.action;
    assign st.bad_id     = (cmd_reg.task_id == '0);
    assign st.last_slot  = (idx_reg == IDX_LAST);
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = !out_valid_reg || rsp_ready;

    always_comb
    begin
        if (cmd_reg.action == ACT_SCAN)
        begin
            fail_code = ST_NO_MATCH;
        end
        else if (st.bad_id)
        begin
            fail_code = ST_BAD_ID;
        end
        else if (cmd_reg.action == ACT_ADD)
        begin
            fail_code = ST_FULL;
        end
        else
        begin
            fail_code = ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        out_next = '0;
        case (cmd.emit)
            EM_FAIL:
            begin
                out_next.status      = fail_code;
                out_next.last_result = 1'b1;
            end
            EM_SLOT:
            begin
                out_next.status      = ST_OK;
                out_next.slot_index  = SLOT_W'(idx_reg);
                out_next.last_result = 1'b1;
            end
            EM_PEND, EM_PEND_LAST:
            begin
                out_next.status          = ST_OK;
                out_next.slot_index      = SLOT_W'(pend_idx_reg);
                out_next.matched_id      = pend_id_reg;
                out_next.matched_handler = pend_tag_reg;
                out_next.last_result     = (cmd.emit == EM_PEND_LAST);
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                ident_reg[i]  <= '0;
                events_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit == EM_PEND_LAST)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit != EM_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.wr)
            begin
                if (cmd_reg.action == ACT_ADD)
                begin
                    ident_reg[idx_reg]  <= cmd_reg.task_id;
                    events_reg[idx_reg] <= add_events;
                end
                else
                begin
                    ident_reg[idx_reg]  <= '0;
                    events_reg[idx_reg] <= '0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= req_data;
            cmd_due_reg <= req_data.use_delay ? (req_data.now_ticks + req_data.delay_ticks)
                                              : '0;
        end
        if (cmd.wr && (cmd_reg.action == ACT_ADD))
        begin
            due_reg[idx_reg]     <= cmd_due_reg;
            handler_reg[idx_reg] <= cmd_reg.handler_tag;
        end
        if (cmd.pend_load)
        begin
            pend_idx_reg <= idx_reg;
            pend_id_reg  <= cur_ident;
            pend_tag_reg <= handler_reg[idx_reg];
        end
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import etd_pkg::*;

    // Random words per threshold setting, and how many idle cycles to leave after the
    // last answer before the threshold may change. An ignored action-3 word has no
    // answer, so hold off for longer than the longest walk.
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 60;
    localparam int DRAIN_GAP   = 40;
    localparam int DRAIN_LIMIT = 200000;

    typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    etd_req_if req_ch ();
    etd_rsp_if rsp_ch ();

    event_timed_task_dispatch_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the task table and the late threshold
    logic [ID_W-1:0]   tbl_ident   [TABLE_DEPTH];
    logic [MASK_W-1:0] tbl_events  [TABLE_DEPTH];
    logic [TICK_W-1:0] tbl_due     [TABLE_DEPTH];
    logic [TAG_W-1:0]  tbl_handler [TABLE_DEPTH];
    logic [THR_W-1:0]  late_thr;

    req_t  request_backlog [$];   // words not yet offered on req
    rsp_t  answers_owed    [$];   // answer words still to come, oldest first
    req_t  on_bus;                // word currently offered on req
    pace_t pace_mode = PACE_NONE;

    int fail_cnt       = 0;
    int words_issued   = 0;
    int words_accepted = 0;
    int answers_seen   = 0;
    int scan_matches   = 0;
    int full_answers   = 0;

    // Generator state: a running time base, the span of delays and advances that
    // keeps timed tasks near their window, and the due time of the last timed add.
    logic [TICK_W-1:0] gen_now       = '0;
    logic [TICK_W-1:0] last_due      = '0;
    int                gen_span      = 3000;
    int                zombie_budget = 2;

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // A live slot fires when its mask meets the event byte; a timed slot also needs
    // now - due, read as signed 32 bits, inside [0, late_thr).
    function automatic bit task_is_due(input int i, input logic [MASK_W-1:0] ev,
                                       input logic [TICK_W-1:0] now);
        logic [TICK_W-1:0] age;
        age = now - tbl_due[i];
        if ((tbl_events[i] & ev) == '0)
            return 1'b0;
        if ((tbl_events[i] & TIME_MASK) == '0)
            return 1'b1;
        return !age[TICK_W-1] && (age < {1'b0, late_thr});
    endfunction

    // Update the shadow table for one accepted word and queue the answers it owes.
    task automatic apply_request(input req_t w);
        rsp_t a;
        bit   fire [TABLE_DEPTH];
        int   slot;
        int   hits;
        int   sent;
        a = '0;
        a.last_result = 1'b1;
        slot = -1;
        hits = 0;
        sent = 0;
        case (w.action)
            ACT_ADD:
            begin
                if (w.task_id == '0)
                    a.status = ST_BAD_ID;
                else
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot < 0 && tbl_ident[i] == '0)
                            slot = i;
                    if (slot < 0)
                    begin
                        a.status = ST_FULL;
                        full_answers++;
                    end
                    else
                    begin
                        tbl_ident[slot]   = w.task_id;
                        tbl_handler[slot] = w.handler_tag;
                        if (w.use_delay)
                        begin
                            tbl_events[slot] = w.trigger_mask | TIME_MASK;
                            tbl_due[slot]    = w.now_ticks + w.delay_ticks;
                        end
                        else
                        begin
                            tbl_events[slot] = w.trigger_mask;
                            tbl_due[slot]    = '0;
                        end
                        a.status     = ST_OK;
                        a.slot_index = SLOT_W'(slot);
                    end
                end
                answers_owed.push_back(a);
            end
            ACT_REMOVE:
            begin
                if (w.task_id == '0)
                    a.status = ST_BAD_ID;
                else
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot < 0 && tbl_events[i] != '0 && tbl_ident[i] == w.task_id)
                            slot = i;
                    if (slot < 0)
                        a.status = ST_NOT_FOUND;
                    else
                    begin
                        tbl_ident[slot]  = '0;
                        tbl_events[slot] = '0;
                        a.status         = ST_OK;
                        a.slot_index     = SLOT_W'(slot);
                    end
                end
                answers_owed.push_back(a);
            end
            ACT_SCAN:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    fire[i] = tbl_events[i] != '0 && task_is_due(i, w.event_mask, w.now_ticks);
                    if (fire[i])
                        hits++;
                end
                if (hits == 0)
                begin
                    a.status = ST_NO_MATCH;
                    answers_owed.push_back(a);
                end
                else
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (fire[i])
                        begin
                            sent++;
                            a.status          = ST_OK;
                            a.slot_index      = SLOT_W'(i);
                            a.matched_id      = tbl_ident[i];
                            a.matched_handler = tbl_handler[i];
                            a.last_result     = (sent == hits);
                            answers_owed.push_back(a);
                        end
                end
                scan_matches += hits;
            end
            default:
            begin
                // action 3: dropped, no answer and no table change
            end
        endcase
    endtask

    task automatic queue_request(input act_t act, input logic [ID_W-1:0] id,
                                 input logic [MASK_W-1:0] tm, input logic ud,
                                 input logic [TICK_W-1:0] dly, input logic [TAG_W-1:0] tag,
                                 input logic [TICK_W-1:0] now, input logic [MASK_W-1:0] ev);
        req_t w;
        w.action       = act;
        w.task_id      = id;
        w.trigger_mask = tm;
        w.use_delay    = ud;
        w.delay_ticks  = dly;
        w.handler_tag  = tag;
        w.now_ticks    = now;
        w.event_mask   = ev;
        request_backlog.push_back(w);
        words_issued++;
    endtask

    // One random word. Adds, removes and scans work on a small id pool and a time
    // base near the due times, so removes hit, the table fills and timed tasks sit
    // on both sides of their window. Action-3 noise does not count toward the total.
    task automatic queue_random_request(output bit counted);
        int                pick;
        int                when;
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] tm;
        logic              ud;
        logic [TICK_W-1:0] dly;
        logic [TICK_W-1:0] now;
        logic [MASK_W-1:0] ev;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        id  = chance(10) ? ID_W'($urandom_range(0, 255)) : ID_W'($urandom_range(1, 12));
        tm  = chance(35) ? MASK_W'($urandom()) : MASK_W'(1 << $urandom_range(0, 7));
        ud  = 1'($urandom_range(0, 1));
        dly = (!ud || chance(10)) ? $urandom() : TICK_W'($urandom_range(0, gen_span));
        ev  = MASK_W'($urandom()) | (chance(50) ? TIME_MASK : '0);
        now = gen_now;
        if (pick < 28)
        begin
            // an empty untimed mask locks a slot until reset: allow only a couple
            if (!ud && tm == '0)
            begin
                if (zombie_budget > 0)
                    zombie_budget--;
                else
                    tm = MASK_W'(8'h40);
            end
            if (ud)
                last_due = gen_now + dly;
            queue_request(ACT_ADD, id, tm, ud, dly, TAG_W'($urandom()), now, ev);
        end
        else if (pick < 60)
            queue_request(ACT_REMOVE, id, tm, ud, dly, TAG_W'($urandom()), now, ev);
        else if (pick < 95)
        begin
            gen_now = gen_now + TICK_W'($urandom_range(0, gen_span / 4));
            when = $urandom_range(0, 9);
            if (when < 5)
                now = gen_now;
            else if (when < 7)
                now = last_due + TICK_W'($urandom_range(0, 2));
            else if (when < 8)
                now = last_due - 1;
            else
                now = $urandom();
            queue_request(ACT_SCAN, id, tm, ud, dly, TAG_W'($urandom()), now, ev);
        end
        else if (pick < 98)
        begin
            queue_request(ACT_NONE, id, tm, ud, dly, TAG_W'($urandom()), $urandom(), ev);
            counted = 1'b0;
        end
        else
            queue_request(chance(50) ? ACT_ADD : ACT_REMOVE, '0, tm, ud, dly,
                          TAG_W'($urandom()), now, ev);
    endtask

    // Wait until every issued word is taken and every owed answer is in, then hold
    // off long enough for a trailing action-3 word to finish its walk.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((words_accepted != words_issued || answers_owed.size() != 0) &&
               waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        late_thr = value;
    endtask

    // Request driver: predict a word when it is taken, then offer the next one
    // unless this cycle is a sender gap. Valid gets one assignment per edge.
    always @(posedge clk)
    begin : request_driver
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(on_bus);
                words_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_backlog.size() != 0 &&
                    !chance(pace_mode == PACE_SENDER ? 57 : pace_mode == PACE_BOTH ? 31 : 0))
                begin
                    on_bus = request_backlog.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.action       <= on_bus.action;
                    req_ch.task_id      <= on_bus.task_id;
                    req_ch.trigger_mask <= on_bus.trigger_mask;
                    req_ch.use_delay    <= on_bus.use_delay;
                    req_ch.delay_ticks  <= on_bus.delay_ticks;
                    req_ch.handler_tag  <= on_bus.handler_tag;
                    req_ch.now_ticks    <= on_bus.now_ticks;
                    req_ch.event_mask   <= on_bus.event_mask;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Answer monitor: check each taken word against the oldest owed answer, and
    // stall ready at random as the pacing mode asks.
    always @(posedge clk)
    begin : answer_monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                answers_seen++;
                if (answers_owed.size() == 0)
                begin
                    $error("answer word with nothing owed: status %0d slot %0d id %0d",
                           rsp_ch.status, rsp_ch.slot_index, rsp_ch.matched_id);
                    fail_cnt++;
                end
                else
                begin
                    want = answers_owed.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_cnt++;
                    end
                    if (rsp_ch.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, rsp_ch.slot_index);
                        fail_cnt++;
                    end
                    if (rsp_ch.matched_id !== want.matched_id)
                    begin
                        $error("matched_id: expected %0d, got %0d",
                               want.matched_id, rsp_ch.matched_id);
                        fail_cnt++;
                    end
                    if (rsp_ch.matched_handler !== want.matched_handler)
                    begin
                        $error("matched_handler: expected %0d, got %0d",
                               want.matched_handler, rsp_ch.matched_handler);
                        fail_cnt++;
                    end
                    if (rsp_ch.last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, rsp_ch.last_result);
                        fail_cnt++;
                    end
                end
            end
            rsp_ch.ready <= !chance(pace_mode == PACE_RECEIVER ? 57 :
                                    pace_mode == PACE_BOTH ? 31 : 0);
        end
    end

    initial
    begin : stimulus
        logic [THR_W-1:0] thr_next;
        bit               counted;
        int               counted_words;

        // Drive every input to a known level from time zero.
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = '0;
        req_ch.task_id      = '0;
        req_ch.trigger_mask = '0;
        req_ch.use_delay    = 1'b0;
        req_ch.delay_ticks  = '0;
        req_ch.handler_tag  = '0;
        req_ch.now_ticks    = '0;
        req_ch.event_mask   = '0;
        rsp_ch.ready        = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_ident[i]   = '0;
            tbl_events[i]  = '0;
            tbl_due[i]     = '0;
            tbl_handler[i] = '0;
        end
        late_thr = THR_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty scan, zero ids, dropped action, then fill all 16
        // slots with extremes, an empty untimed mask, timed tasks with and without
        // wrap, and a duplicate id; then overflow, scan, and removes.
        queue_request(ACT_SCAN,   8'd0, 8'h00, 1'b0, '0, 8'h00, '0, 8'hFF);
        queue_request(ACT_ADD,    8'd0, 8'hFF, 1'b0, '0, 8'h5A, '0, 8'h00);
        queue_request(ACT_REMOVE, 8'd0, 8'h00, 1'b0, '0, 8'h00, '0, 8'h00);
        queue_request(ACT_NONE,   8'hFF, 8'hFF, 1'b1, '1, 8'hFF, '1, 8'hFF);
        queue_request(ACT_ADD,    8'hFF, 8'hFF, 1'b0, '1, 8'hFF, '1, 8'h00);
        queue_request(ACT_ADD,    8'd1, 8'h00, 1'b0, 32'd5, 8'h11, 32'd0, 8'h00);
        queue_request(ACT_ADD,    8'd2, 8'h00, 1'b1, 32'd0, 8'h22, 32'd100, 8'h00);
        queue_request(ACT_ADD,    8'd3, 8'h80, 1'b1, '1, 8'h33, '1, 8'h00);
        queue_request(ACT_ADD,    8'd7, 8'h02, 1'b0, 32'd0, 8'h70, 32'd0, 8'h00);
        queue_request(ACT_ADD,    8'd7, 8'h04, 1'b0, 32'd0, 8'h71, 32'd0, 8'h00);
        queue_request(ACT_ADD,    8'd4, 8'h01, 1'b1, 32'd50, 8'h44, 32'd1000, 8'h00);
        for (int k = 0; k < 9; k++)
            queue_request(ACT_ADD, ID_W'(8 + k), MASK_W'(1 << (k % 8)), 1'b0, '0,
                          TAG_W'(8'h80 + k), '0, 8'h00);
        queue_request(ACT_ADD,    8'd9, 8'h01, 1'b0, '0, 8'h99, '0, 8'h00);
        queue_request(ACT_SCAN,   8'd0, 8'h00, 1'b0, '0, 8'h00, 32'd1050, 8'hFF);
        queue_request(ACT_REMOVE, 8'd7, 8'h00, 1'b0, '0, 8'h00, '0, 8'h00);
        queue_request(ACT_REMOVE, 8'd1, 8'h00, 1'b0, '0, 8'h00, '0, 8'h00);
        queue_request(ACT_REMOVE, 8'd200, 8'h00, 1'b0, '0, 8'h00, '0, 8'h00);

        // Random phases: each one a threshold setting and a pacing mode. Change
        // the threshold only once the block has gone quiet.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_drained();
                case (p)
                    1:       thr_next = '0;
                    2:       thr_next = THR_W'(1);
                    3:       thr_next = '1;
                    4:       thr_next = THR_W'($urandom_range(1, 5000));
                    5:       thr_next = THR_RESET;
                    6:       thr_next = THR_W'($urandom_range(1, 32'h7FFF_FFFF));
                    default: thr_next = THR_W'($urandom_range(2, 64));
                endcase
                write_threshold(thr_next);
            end
            pace_mode = pace_t'(p % 4);
            gen_span  = (late_thr == '0 || late_thr > 3000) ? 3000 : 2 * int'(late_thr) + 4;
            gen_now   = $urandom();
            last_due  = gen_now;
            counted_words = 0;
            while (counted_words < PHASE_WORDS)
            begin
                queue_random_request(counted);
                if (counted)
                    counted_words++;
            end
        end

        wait_drained();
        if (answers_owed.size() != 0)
        begin
            $error("%0d owed answer words never arrived", answers_owed.size());
            fail_cnt++;
        end

        $display("Covered %0d request words and %0d answer words (%0d scan matches, %0d full).",
                 words_accepted, answers_seen, scan_matches, full_answers);
        $display("Thresholds reset, zero, one, maximum and random; pacing none, gaps, stalls, both.");
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run with every stall mode.
    initial
    begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
